// ----- design/qlar_pkg.sv -----
// Shared types and constants for the QoS level alert and recovery core.
package qlar_pkg;

   localparam int TIME_BITS  = 32;
   localparam int PAUSE_W    = 32;
   localparam int LEVEL_W    = 4;
   localparam int CMP_W      = (TIME_BITS > PAUSE_W) ? TIME_BITS : PAUSE_W;
   localparam int CSR_DATA_W = (PAUSE_W > LEVEL_W) ? PAUSE_W : LEVEL_W;
   localparam int REQ_DATA_W = ((TIME_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((LEVEL_W + 3 + 7) / 8) * 8;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP       = '1;
   localparam logic [LEVEL_W-1:0] STOP_LEVEL_INIT = LEVEL_W'(10);

   typedef enum logic [1:0] {
      CSR_ALERT_PAUSE    = 2'd0,
      CSR_RECOVERY_PAUSE = 2'd1,
      CSR_BASE_LEVEL     = 2'd2,
      CSR_STOP_LEVEL     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PAUSE_W-1:0] alert_pause;
      logic [PAUSE_W-1:0] recovery_pause;
      logic [LEVEL_W-1:0] base_level;
      logic [LEVEL_W-1:0] stop_level;
   } cfg_type;

   typedef struct packed {
      logic               load;
      logic [LEVEL_W-1:0] level;
   } level_load_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   level;
      logic [TIME_BITS-1:0] last_alert;
      logic [TIME_BITS-1:0] last_recovery;
      logic                 halted;
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] qos_level;
      logic               raised;
      logic               lowered;
      logic               stopped;
   } result_type;

endpackage

// ----- design/qos_level_alert_recovery_core.sv -----
// Top level of the QoS level alert and recovery core.
//
// Each request beat carries a millisecond timestamp and a pass or fail
// verdict; each one produces exactly one response beat holding the level
// after that beat and the raised, lowered and stopped flags.
// The request beat is captured in an input register at the accepting edge.
// The update logic then evaluates it against the held level and the two
// timer stamps, and the result is registered in the response register
// when the beat moves on, which it does only when the response register
// is empty or being drained; the response beat is presented from there.
// Throughput is one beat per cycle while the receiver keeps rsp_tready
// high: the input register refills in the same cycle that it hands its
// beat on.
// When the receiver stalls, the response register holds its beat and the
// input register holds one more; req_tready then falls until rsp_tready
// returns, and no beat is lost or repeated.
// The configuration port writes a register at any clock edge with csr_we
// high; writing base_level also loads the level. Writes are expected only
// while no beat is in flight.
// Synchronous reset clears both stages, the level, the timer stamps and
// the stopped flag, and restores the register defaults. Once stopped, the
// core answers every beat with the held level until the next reset.
module qos_level_alert_recovery_core
   import qlar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata, from bit 0: now_ms, measure_ok, zero padding
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata, from bit 0: qos_level, raised, lowered, stopped, zero padding
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type              cfg;
   level_load_type       level_load;
   state_type            state_ff;
   state_type            state_in;
   state_type            state_next;
   result_type           result;
   result_type           rsp_ff;
   logic                 in_valid_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 in_ok_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_take;

   qlar_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .level_load (level_load)
   );

   qlar_update u_update (
      .cfg        (cfg),
      .state      (state_ff),
      .now_ms     (in_now_ff),
      .measure_ok (in_ok_ff),
      .state_next (state_next),
      .result     (result)
   );

   // A beat moves on when the response register is empty or being drained.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = state_next;
      end
      if (level_load.load) begin
         state_in.level = level_load.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.level         <= '0;
         state_ff.last_alert    <= '0;
         state_ff.last_recovery <= '0;
         state_ff.halted        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff <= req_tdata[TIME_BITS-1:0];
         in_ok_ff  <= req_tdata[TIME_BITS];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.stopped, rsp_ff.lowered, rsp_ff.raised,
                                    rsp_ff.qos_level});

endmodule

// ----- design/qlar_csr.sv -----
// Configuration register bank with the level load strobe.
module qlar_csr
   import qlar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output level_load_type        level_load
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;

   assign index = csr_index_type'(csr_index);

   always_comb begin
      cfg_in           = cfg_ff;
      level_load.load  = 1'b0;
      level_load.level = csr_wdata[LEVEL_W-1:0];
      if (csr_we) begin
         unique case (index)
            CSR_ALERT_PAUSE:    cfg_in.alert_pause    = csr_wdata[PAUSE_W-1:0];
            CSR_RECOVERY_PAUSE: cfg_in.recovery_pause = csr_wdata[PAUSE_W-1:0];
            CSR_BASE_LEVEL: begin
               cfg_in.base_level = csr_wdata[LEVEL_W-1:0];
               level_load.load   = 1'b1;
            end
            CSR_STOP_LEVEL:     cfg_in.stop_level     = csr_wdata[LEVEL_W-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alert_pause    <= '0;
         cfg_ff.recovery_pause <= '0;
         cfg_ff.base_level     <= '0;
         cfg_ff.stop_level     <= STOP_LEVEL_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/qlar_update.sv -----
// Next-state and result logic for one measurement beat.
module qlar_update
   import qlar_pkg::*;
(
   input  cfg_type              cfg,
   input  state_type            state,
   input  logic [TIME_BITS-1:0] now_ms,
   input  logic                 measure_ok,
   output state_type            state_next,
   output result_type           result
);

   logic [TIME_BITS-1:0] alert_elapsed;
   logic [TIME_BITS-1:0] recovery_stamp;
   logic [TIME_BITS-1:0] recovery_elapsed;
   logic                 alert_due;
   logic                 recovery_due;
   logic                 raised;
   logic                 lowered;

   assign alert_elapsed    = now_ms - state.last_alert;
   // The later stamp is a plain unsigned compare, without regard to wrap.
   assign recovery_stamp   = (state.last_alert > state.last_recovery) ?
                             state.last_alert : state.last_recovery;
   assign recovery_elapsed = now_ms - recovery_stamp;
   assign alert_due        = CMP_W'(alert_elapsed) > CMP_W'(cfg.alert_pause);
   assign recovery_due     = CMP_W'(recovery_elapsed) > CMP_W'(cfg.recovery_pause);

   always_comb begin
      state_next = state;
      raised     = 1'b0;
      lowered    = 1'b0;
      if (!state.halted) begin
         if (!measure_ok) begin
            if (state.level == cfg.stop_level) begin
               state_next.halted = 1'b1;
            end else if (state.level != LEVEL_TOP && alert_due) begin
               state_next.level      = state.level + LEVEL_W'(1);
               state_next.last_alert = now_ms;
               raised                = 1'b1;
            end
         end else if (state.level > cfg.base_level) begin
            state_next.last_recovery = recovery_stamp;
            if (recovery_due) begin
               state_next.level         = state.level - LEVEL_W'(1);
               state_next.last_recovery = now_ms;
               lowered                  = 1'b1;
            end
         end
      end
      result.qos_level = state_next.level;
      result.raised    = raised;
      result.lowered   = lowered;
      result.stopped   = state_next.halted;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the QoS level alert and recovery core.
module tb_top;
   import qlar_pkg::*;

   // The run is ended here if the core stops handing back beats. The limit
   // leaves a wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 110;
   localparam logic [PAUSE_W-1:0] PAUSE_MAX = '1;

   // The scoreboard carries its own copy of the registers and of the level
   // tracking state. Each accepted request beat is run through that copy at
   // once, and the result that the core should return is queued for the
   // response monitor.
   class qos_level_scoreboard;
      logic [PAUSE_W-1:0]   alert_pause;
      logic [PAUSE_W-1:0]   recovery_pause;
      logic [LEVEL_W-1:0]   base_level;
      logic [LEVEL_W-1:0]   stop_level;
      logic [LEVEL_W-1:0]   level;
      logic [TIME_BITS-1:0] last_alert;
      logic [TIME_BITS-1:0] last_recovery;
      logic                 halted;
      result_type           expected_q[$];
      int                   error_count;

      function new();
         alert_pause    = '0;
         recovery_pause = '0;
         base_level     = '0;
         stop_level     = STOP_LEVEL_INIT;
         level          = '0;
         last_alert     = '0;
         last_recovery  = '0;
         halted         = 1'b0;
         error_count    = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ALERT_PAUSE:    alert_pause = value[PAUSE_W-1:0];
            CSR_RECOVERY_PAUSE: recovery_pause = value[PAUSE_W-1:0];
            CSR_BASE_LEVEL: begin
               base_level = value[LEVEL_W-1:0];
               level      = value[LEVEL_W-1:0];
            end
            CSR_STOP_LEVEL:     stop_level = value[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function bit would_halt(logic measure_ok);
         return !halted && !measure_ok && level == stop_level;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [TIME_BITS-1:0] now_ms, logic measure_ok);
         result_type           r;
         logic [TIME_BITS-1:0] elapsed;
         r.raised  = 1'b0;
         r.lowered = 1'b0;
         if (!halted) begin
            if (!measure_ok) begin
               if (level == stop_level) begin
                  halted = 1'b1;
               end else if (level != LEVEL_TOP) begin
                  elapsed = now_ms - last_alert;
                  if (elapsed > alert_pause) begin
                     level      = level + LEVEL_W'(1);
                     last_alert = now_ms;
                     r.raised   = 1'b1;
                  end
               end
            end else if (level > base_level) begin
               // The later stamp is picked by a plain compare, wrap ignored.
               if (last_alert > last_recovery) last_recovery = last_alert;
               elapsed = now_ms - last_recovery;
               if (elapsed > recovery_pause) begin
                  level         = level - LEVEL_W'(1);
                  last_recovery = now_ms;
                  r.lowered     = 1'b1;
               end
            end
         end
         r.qos_level = level;
         r.stopped   = halted;
         expected_q = {expected_q, r};
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected: qos_level %0d", got.qos_level);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         if (got.qos_level !== want.qos_level) begin
            $error("qos_level mismatch: expected %0d, actual %0d",
                   want.qos_level, got.qos_level);
            error_count++;
         end
         if (got.raised !== want.raised) begin
            $error("raised mismatch: expected %0b, actual %0b", want.raised, got.raised);
            error_count++;
         end
         if (got.lowered !== want.lowered) begin
            $error("lowered mismatch: expected %0b, actual %0b", want.lowered, got.lowered);
            error_count++;
         end
         if (got.stopped !== want.stopped) begin
            $error("stopped mismatch: expected %0b, actual %0b", want.stopped, got.stopped);
            error_count++;
         end
      endfunction
   endclass

   // Every input of the core starts at a known value, with reset held high.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // req_tdata, from bit 0: now_ms, measure_ok, zero padding
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // rsp_tdata, from bit 0: qos_level, raised, lowered, stopped, zero padding
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = CSR_ALERT_PAUSE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   qos_level_scoreboard sb = new();
   int                  cycle_count = 0;
   // The sender runs in bursts; burst_left counts the beats left in the
   // current burst and gaps_on switches the gaps off for whole phases.
   int                  burst_left = 0;
   bit                  gaps_on = 1'b1;
   logic [15:0]         ready_pattern = '1;
   int                  pattern_age = 0;

   qos_level_alert_recovery_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // The receiver follows a rotating ready pattern that is drawn anew when its
   // age counter runs out: sometimes always ready, sometimes random, sparse or dense.
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern = '1;
            1: ready_pattern = 16'($urandom);
            2: ready_pattern = 16'($urandom & $urandom);
            default: ready_pattern = 16'($urandom | $urandom);
         endcase
         pattern_age = $urandom_range(16, 96);
      end else begin
         pattern_age--;
      end
      rsp_tready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
   end

   // Response beats are taken apart at the rising edge and checked in order.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.qos_level = rsp_tdata[LEVEL_W-1:0];
         got.raised    = rsp_tdata[LEVEL_W];
         got.lowered   = rsp_tdata[LEVEL_W+1];
         got.stopped   = rsp_tdata[LEVEL_W+2];
         sb.check_response(got);
      end
   end

   // Registers are written only while nothing is in flight, so the
   // scoreboard copy can be updated as soon as the write edge has passed.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_register(idx, value);
   endtask

   // Presents one request beat and returns once it has been accepted. The
   // valid stays high afterwards so that back-to-back beats need no gap.
   task automatic send_beat(logic [TIME_BITS-1:0] now_ms, logic measure_ok);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({measure_ok, now_ms});
      do @(posedge clock); while (!req_tready);
      sb.note_request(now_ms, measure_ok);
   endtask

   // Holds the sender back until every expected response has come, then
   // lets the two pipeline stages settle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [PAUSE_W-1:0] pick_pause();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PAUSE_MAX;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   // Time mostly creeps forward in small steps, but now and then it jumps to
   // an arbitrary value or steps backwards, which makes the elapsed time wrap.
   function automatic logic [TIME_BITS-1:0] next_time(logic [TIME_BITS-1:0] t);
      case ($urandom_range(0, 19))
         0: return $urandom;
         1: return t - $urandom_range(0, 50);
         default: return t + $urandom_range(0, 25);
      endcase
   endfunction

   initial begin
      logic [TIME_BITS-1:0] now_ms;
      logic                 measure_ok;
      int                   fail_pct;
      logic [LEVEL_W-1:0]   base_pick;
      logic [LEVEL_W-1:0]   stop_pick;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults straight after reset: both pauses zero, base level
      // zero and stop level ten. A pass at the base level does nothing, and a
      // failure at the same millisecond as the last raise is held off because
      // the elapsed time must strictly exceed the pause.
      gaps_on = 1'b0;
      send_beat(32'd0, 1'b1);
      send_beat(32'd0, 1'b0);
      send_beat(32'd1, 1'b0);
      // The alert stamp is newer, so it is copied into the recovery stamp and
      // the decrease is held off in the same millisecond.
      send_beat(32'd1, 1'b1);
      send_beat(32'd2, 1'b1);

      // A stop level below the level never stops the core. With the largest
      // alert pause no elapsed time is long enough for a raise.
      wait_drained();
      write_csr(CSR_ALERT_PAUSE, PAUSE_MAX);
      write_csr(CSR_RECOVERY_PAUSE, '0);
      write_csr(CSR_BASE_LEVEL, CSR_DATA_W'(13));
      write_csr(CSR_STOP_LEVEL, CSR_DATA_W'(2));
      send_beat(32'hFFFF_FFFF, 1'b0);
      wait_drained();
      write_csr(CSR_ALERT_PAUSE, '0);
      // Raises across the wrap of the millisecond counter, up to the top
      // level, where a further raise is suppressed.
      send_beat(32'hFFFF_FFFF, 1'b0);
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'h0000_0007, 1'b0);
      send_beat(32'h0000_0003, 1'b1);
      wait_drained();
      write_csr(CSR_RECOVERY_PAUSE, PAUSE_MAX);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'h8000_0000, 1'b0);
      send_beat(32'h8000_0001, 1'b1);

      // Random phases, each with its own register settings. The first two
      // take the extreme base and stop levels. A failed beat that would stop
      // the core is turned into a pass here, since only reset clears the
      // stopped state and that is kept for the last phase.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // Every phase boundary holds the sender until all responses are in.
         wait_drained();
         base_pick = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : LEVEL_W'($urandom_range(0, 15));
         stop_pick = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : LEVEL_W'($urandom_range(0, 15));
         write_csr(CSR_ALERT_PAUSE, pick_pause());
         write_csr(CSR_RECOVERY_PAUSE, pick_pause());
         // The upper data bits are noise that the level registers must drop.
         write_csr(CSR_BASE_LEVEL, ($urandom & 32'hFFFF_FFF0) | CSR_DATA_W'(base_pick));
         write_csr(CSR_STOP_LEVEL, ($urandom & 32'hFFFF_FFF0) | CSR_DATA_W'(stop_pick));
         gaps_on  = (p % 3 != 2);
         burst_left = 0;
         fail_pct = $urandom_range(20, 70);
         now_ms   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            now_ms     = next_time(now_ms);
            measure_ok = ($urandom_range(0, 99) >= fail_pct);
            if (sb.would_halt(measure_ok)) measure_ok = 1'b1;
            send_beat(now_ms, measure_ok);
         end
      end

      // Last phase: two raises take the level to the stop level and the next
      // failure stops the core. A base level write still loads the held level
      // while stopped, and every later beat only reports it.
      wait_drained();
      write_csr(CSR_ALERT_PAUSE, '0);
      write_csr(CSR_RECOVERY_PAUSE, '0);
      write_csr(CSR_BASE_LEVEL, CSR_DATA_W'(3));
      write_csr(CSR_STOP_LEVEL, CSR_DATA_W'(5));
      gaps_on = 1'b1;
      send_beat(32'd101, 1'b0);
      send_beat(32'd102, 1'b0);
      send_beat(32'd103, 1'b0);
      send_beat(32'd104, 1'b1);
      wait_drained();
      write_csr(CSR_BASE_LEVEL, CSR_DATA_W'(9));
      for (int i = 0; i < 20; i++) begin
         send_beat($urandom, 1'($urandom_range(0, 1)));
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
